// ===== hdl/posit16_log2_fixed_point_assert.svh =====
// Assertion macros for the posit16 log2 block.
`ifndef POSIT16_LOG2_FIXED_POINT_ASSERT_SVH
`define POSIT16_LOG2_FIXED_POINT_ASSERT_SVH
`ifndef SYNTHESIS
`define P16L2_ASSERT_CLK(lbl, clk_sig, rst_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error("posit16 log2 assertion failed");
`define P16L2_ASSERT_NORST(lbl, clk_sig, prop) \
  lbl: assert property (@(posedge clk_sig) prop) \
    else $error("posit16 log2 reset assertion failed");
`else
`define P16L2_ASSERT_CLK(lbl, clk_sig, rst_sig, prop)
`define P16L2_ASSERT_NORST(lbl, clk_sig, prop)
`endif
`endif

// ===== hdl/p16l2_pkg.sv =====
// Package with constants, types and helpers of the posit16 log2 block.
`default_nettype none
package p16l2_pkg;

  localparam logic [15:0] NAR16 = 16'h8000;
  localparam logic [15:0] POSIT_ONE = 16'h4000;

  localparam int QBITS = 28;
  localparam int DIV_STAGES = 7;
  localparam int DIV_STEPS = QBITS / DIV_STAGES;
  localparam int MUL_STAGES = 6;
  localparam int LATENCY = 1 + DIV_STAGES + MUL_STAGES + 3;

  localparam logic [13:0] DIV_BIAS = 14'd8192;
  localparam logic [10:0] C1 = 11'd1661;
  localparam logic [13:0] C2 = 14'd13209;
  localparam logic [16:0] C3 = 17'd75694;
  localparam logic [21:0] C4 = 22'd2017019;
  localparam logic [26:0] C5 = 27'd96817627;

  typedef logic signed [5:0] scale_t;
  typedef logic [11:0] frac_t;
  typedef logic [QBITS-1:0] quot_t;

  function automatic logic [3:0] lead_ones14(input logic [13:0] s);
    logic [3:0] n;
    logic run;
    n = 4'd0;
    run = 1'b1;
    for (int i = 13; i >= 0; i--) begin
      run = run & s[i];
      n = n + {3'b000, run};
    end
    return n;
  endfunction

  function automatic logic [4:0] lead_zeros28(input logic [27:0] a);
    logic [4:0] n;
    logic run;
    n = 5'd0;
    run = 1'b1;
    for (int i = 27; i >= 0; i--) begin
      run = run & ~a[i];
      n = n + {4'b0000, run};
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/posit16_log2_fixed_point.sv =====
// Top level of the pipelined posit16 (es=1) base-2 logarithm.
//
// Usage: drive posit_in and pulse start; a transaction is taken at every
// rising edge with start high and busy low. busy is always low, so one
// operand may be issued every cycle, back to back.
// Each result appears on log_out together with a one-cycle done strobe,
// in issue order. The pipeline holds one decode stage, a seven-stage
// restoring divider (four quotient bits per stage), six multiply stages
// of the polynomial and three renormalize/round stages.
// Throughput is one result per cycle.
// Zero, NaR and negative operands give NaR (0x8000).
// rst (synchronous, active high) clears all stage valid bits; operands in
// flight are dropped and no done strobe follows.
// The receiver cannot stall: results must be taken when done is high.
`default_nettype none
`include "posit16_log2_fixed_point_assert.svh"
module posit16_log2_fixed_point
  import p16l2_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] posit_in,
  output logic             done,
  output logic [15:0]      log_out
);

  logic accept;
  assign busy = 1'b0;
  assign accept = start && !busy;

  // decode
  logic        pos;
  logic [13:0] run_bits;
  logic [3:0]  nrun;
  logic [12:0] mexp;
  scale_t      sc_in;
  logic        nar_in;

  always_comb begin
    pos = posit_in[14];
    run_bits = pos ? posit_in[13:0] : ~posit_in[13:0];
    nrun = lead_ones14(run_bits);
    mexp = posit_in[12:0] << nrun;
    nar_in = (posit_in == 16'h0000) || posit_in[15];
    if (pos) begin
      sc_in = scale_t'({1'b0, nrun, 1'b0} | {5'b00000, mexp[12]});
    end else begin
      sc_in = scale_t'((6'h3E - {1'b0, nrun, 1'b0}) | {5'b00000, mexp[12]});
    end
  end

  // divider pipeline, index 0 is the decode register
  logic        dv_vld [0:DIV_STAGES];
  logic        dv_nar [0:DIV_STAGES];
  scale_t      dv_sc  [0:DIV_STAGES];
  logic [13:0] dv_d   [0:DIV_STAGES];
  logic [13:0] dv_r   [0:DIV_STAGES];
  quot_t       dv_q   [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else begin
      dv_vld[0] <= accept;
    end
    dv_nar[0] <= nar_in;
    dv_sc[0]  <= sc_in;
    dv_d[0]   <= 14'({2'b00, mexp[11:0]}) + DIV_BIAS;
    dv_r[0]   <= {1'b0, mexp[11:0], 1'b0};
    dv_q[0]   <= '0;
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    logic [13:0] r_next;
    quot_t       q_next;
    logic [14:0] t;

    always_comb begin
      r_next = dv_r[k-1];
      q_next = dv_q[k-1];
      t = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
        t = {r_next, 1'b0};
        if (t >= {1'b0, dv_d[k-1]}) begin
          t = t - {1'b0, dv_d[k-1]};
          q_next = {q_next[QBITS-2:0], 1'b1};
        end else begin
          q_next = {q_next[QBITS-2:0], 1'b0};
        end
        r_next = t[13:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k] <= 1'b0;
      end else begin
        dv_vld[k] <= dv_vld[k-1];
      end
      dv_nar[k] <= dv_nar[k-1];
      dv_sc[k]  <= dv_sc[k-1];
      dv_d[k]   <= dv_d[k-1];
      dv_r[k]   <= r_next;
      dv_q[k]   <= q_next;
    end
  end

  // polynomial multiply chain
  logic        mu_vld [1:MUL_STAGES];
  logic        mu_nar [1:MUL_STAGES];
  scale_t      mu_sc  [1:MUL_STAGES];
  quot_t       mu_z   [1:MUL_STAGES-1];
  logic [24:0] mu_zz  [1:MUL_STAGES-1];
  logic [11:0] t1;
  logic [13:0] t2;
  logic [18:0] t3;
  logic [23:0] t4;
  logic [27:0] t5;

  logic [55:0] p0;
  logic [35:0] p1;
  logic [39:0] p2;
  logic [42:0] p3;
  logic [47:0] p4;
  logic [54:0] p5;

  always_comb begin
    p0 = 56'(dv_q[DIV_STAGES]) * 56'(dv_q[DIV_STAGES]);
    p1 = 36'(mu_zz[1]) * 36'(C1);
    p2 = 40'(mu_zz[2]) * (40'(C2) + 40'(t1));
    p3 = 43'(mu_zz[3]) * (43'(C3) + 43'(t2));
    p4 = 48'(mu_zz[4]) * (48'(C4) + 48'(t3));
    p5 = 55'(mu_z[5]) * (55'(C5) + 55'(t4));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= MUL_STAGES; i++) begin
        mu_vld[i] <= 1'b0;
      end
    end else begin
      mu_vld[1] <= dv_vld[DIV_STAGES];
      for (int i = 2; i <= MUL_STAGES; i++) begin
        mu_vld[i] <= mu_vld[i-1];
      end
    end
    mu_nar[1] <= dv_nar[DIV_STAGES];
    mu_sc[1]  <= dv_sc[DIV_STAGES];
    mu_z[1]   <= dv_q[DIV_STAGES];
    mu_zz[1]  <= p0[54:30];
    for (int i = 2; i <= MUL_STAGES; i++) begin
      mu_nar[i] <= mu_nar[i-1];
      mu_sc[i]  <= mu_sc[i-1];
    end
    for (int i = 2; i <= MUL_STAGES - 1; i++) begin
      mu_z[i]  <= mu_z[i-1];
      mu_zz[i] <= mu_zz[i-1];
    end
    t1 <= {1'b0, p1[35:25]};
    t2 <= p2[39:26];
    t3 <= p3[42:24];
    t4 <= p4[47:24];
    t5 <= p5[53:26];
  end

  // magnitude
  logic [33:0] acc;
  logic        o1_vld, o1_nar, o1_neg;
  logic [33:0] o1_mag;

  assign acc = {mu_sc[MUL_STAGES], t5};

  always_ff @(posedge clk) begin
    if (rst) begin
      o1_vld <= 1'b0;
    end else begin
      o1_vld <= mu_vld[MUL_STAGES];
    end
    o1_nar <= mu_nar[MUL_STAGES];
    o1_neg <= acc[33];
    o1_mag <= acc[33] ? (34'd0 - acc) : acc;
  end

  // normalize into posit layout
  logic [4:0]  nz;
  logic [27:0] norm;
  logic [2:0]  lsh;
  logic [33:0] sv;
  logic [1:0]  lsh2;
  logic [33:0] pre;
  logic [4:0]  rsh;

  always_comb begin
    nz = lead_zeros28(o1_mag[27:0]);
    norm = o1_mag[27:0] << nz;
    lsh = 3'd0;
    for (int i = 29; i <= 33; i++) begin
      if (o1_mag[i]) begin
        lsh = 3'(i - 28);
      end
    end
    sv = o1_mag;
    for (int i = 0; i < 5; i++) begin
      if (3'(i) < lsh) begin
        sv = {1'b0, sv[33:1]} | {33'd0, sv[1] | sv[0]};
      end
    end
    lsh2 = lsh[2:1];
    if (o1_mag == 34'd0) begin
      pre = '0;
      rsh = 5'd16;
    end else if (o1_mag[33:28] == 6'd0) begin
      pre = {5'b00000, 1'b1, ~nz[0], norm[26:0]};
      rsh = 5'd15 + {1'b0, nz[4:1]};
    end else begin
      pre = {6'd0, sv[27:0]} | {5'd0, lsh[0], 28'd0}
          | ((34'h080000000 << lsh2) - 34'h040000000);
      rsh = 5'd16 + {3'b000, lsh2};
    end
  end

  logic        o2_vld, o2_nar, o2_neg;
  logic [33:0] o2_pre;
  logic [4:0]  o2_rsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      o2_vld <= 1'b0;
    end else begin
      o2_vld <= o1_vld;
    end
    o2_nar <= o1_nar;
    o2_neg <= o1_neg;
    o2_pre <= pre;
    o2_rsh <= rsh;
  end

  // round to nearest even, restore sign
  logic [5:0]  gpos;
  logic [33:0] q;
  logic [33:0] low_mask;
  logic        guard, sticky, rnd;
  logic [15:0] rmag;
  logic [15:0] result;

  always_comb begin
    gpos = {1'b0, o2_rsh} - 6'd1;
    q = o2_pre >> o2_rsh;
    low_mask = (34'd1 << gpos) - 34'd1;
    guard = o2_pre[gpos];
    sticky = |(o2_pre & low_mask);
    rnd = guard && (sticky || q[0]);
    rmag = q[15:0] + {15'd0, rnd};
    if (o2_nar) begin
      result = NAR16;
    end else if (o2_neg) begin
      result = 16'd0 - rmag;
    end else begin
      result = rmag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= o2_vld;
    end
    log_out <= result;
  end

  `P16L2_ASSERT_CLK(a_latency, clk, rst, accept |-> ##LATENCY done)
  `P16L2_ASSERT_CLK(a_nar, clk, rst, accept && posit_in[15] |-> ##LATENCY log_out == NAR16)
  `P16L2_ASSERT_CLK(a_one, clk, rst, accept && posit_in == POSIT_ONE |-> ##LATENCY log_out == 16'h0000)
  `P16L2_ASSERT_NORST(a_rst_quiet, clk, rst |=> !done)

endmodule
`default_nettype wire

// ===== test/posit16_log2_checker.sv =====
// Checker that predicts posit16 log2 results and compares them with the block output.
module posit16_log2_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] posit_in,
  input  logic        done,
  input  logic [15:0] log_out,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import p16l2_pkg::*;

  logic [15:0] log_queue[$];

  function automatic logic [63:0] mantissa_log2(input logic [63:0] fr);
    logic [63:0] z, zz, t;
    z = (fr << 29) / (fr + 64'd8192);
    zz = (z * z) >> 30;
    t = (zz * 64'd1661) >> 25;
    t = (zz * (64'd13209 + t)) >> 26;
    t = (zz * (64'd75694 + t)) >> 24;
    t = (zz * (64'd2017019 + t)) >> 24;
    t = (z * (64'd96817627 + t)) >> 26;
    return t;
  endfunction

  function automatic logic [63:0] round_even(input logic [63:0] a, input logic [63:0] rb);
    if ((a & rb) != 0 && ((a & (rb - 1)) != 0 || (a & (rb << 1)) != 0))
      a = a + rb;
    return a;
  endfunction

  function automatic logic [15:0] posit_log2(input logic [15:0] x);
    logic [63:0] v, acc, rb;
    int sc, sh;
    logic neg;
    if (x == 16'h0 || x[15])
      return NAR16;
    v = {48'h0, x};
    if (v[14]) begin
      sc = 0;
      for (int i = 0; i < 16 && v[13]; i++) begin
        v = v << 1;
        sc += 2;
      end
    end else begin
      sc = -2;
      for (int i = 0; i < 16 && !v[13]; i++) begin
        v = v << 1;
        sc -= 2;
      end
    end
    if (v[12])
      sc++;
    v = v & 64'hFFF;
    acc = (v != 0) ? mantissa_log2(v) : 64'd0;
    acc = acc | (64'(sc < 0 ? 64 + sc : sc) << 28);
    neg = acc[33];
    if (neg)
      acc = 64'h400000000 - acc;
    if (acc < 64'h10000000) begin
      if (acc != 0) begin
        sh = 30;
        for (int i = 0; i < 28 && !acc[27]; i++) begin
          acc = acc << 1;
          sh++;
        end
        acc = (acc ^ 64'h18000000) | (64'(1 ^ (sh & 1)) << 27);
        sh = sh >> 1;
        rb = 64'd1 << (sh - 1);
        acc = round_even(acc, rb);
        acc = acc >> sh;
      end
    end else begin
      sh = 0;
      for (int i = 0; i < 8 && acc > 64'h1FFFFFFF; i++) begin
        acc = (acc & 64'd1) | (acc >> 1);
        sh++;
      end
      acc = acc & 64'hFFFFFFF;
      if (sh & 1)
        acc = acc | 64'h10000000;
      sh = sh >> 1;
      acc = acc | ((64'h80000000 << sh) - 64'h40000000);
      rb = 64'h8000 << sh;
      acc = round_even(acc, rb);
      acc = acc >> (sh + 16);
    end
    if (neg)
      acc = 64'h10000 - acc;
    return acc[15:0];
  endfunction

  assign pending = log_queue.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (log_queue.size() == 0) begin
          $error("unexpected transaction on log_out: %h", log_out);
          fail_count <= fail_count + 1;
        end else if (log_queue[0] !== log_out) begin
          $error("log_out: expected %h, actual %h", log_queue[0], log_out);
          fail_count <= fail_count + 1;
          void'(log_queue.pop_front());
        end else
          void'(log_queue.pop_front());
      end
      if (start && !busy)
        log_queue.push_back(posit_log2(posit_in));
    end
  end
endmodule

// ===== test/testbench.sv =====
// Testbench top for the posit16 log2 block: stimulus, watchdog and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import p16l2_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [15:0] posit_in = 16'h0;
  logic busy, done;
  logic [15:0] log_out;
  int fail_count, pending, idle_cycles;
  logic [15:0] directed[$];

  always #2 clk = ~clk;

  posit16_log2_fixed_point dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .posit_in(posit_in), .done(done), .log_out(log_out));

  posit16_log2_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .posit_in(posit_in),
    .done(done), .log_out(log_out), .fail_count(fail_count), .pending(pending));

  always @(posedge clk) begin
    if (rst || (start && !busy) || done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic issue(input logic [15:0] operand, input logic quiet);
    if (!quiet && $urandom_range(99) < 9) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    posit_in <= operand;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] random_posit();
    int pick;
    logic [15:0] p;
    pick = $urandom_range(99);
    p = 16'($urandom_range(16'hFFFF));
    if (pick < 70)
      p[15] = 1'b0;
    else if (pick < 80)
      p = {3'b0, p[12:0] >> $urandom_range(12)};
    else if (pick < 90)
      p = {1'b0, {14{1'b1}} << $urandom_range(13), 1'b0} | (p & 16'h0007);
    return p;
  endfunction

  initial begin
    directed = '{16'h0000, 16'h8000, 16'hFFFF, 16'hC000, 16'h4000, 16'h0001,
                 16'h7FFF, 16'h7FFE, 16'h5000, 16'h3000, 16'h4001, 16'h3FFF,
                 16'h4FFF, 16'h2000, 16'h6000, 16'h0002, 16'h0003, 16'h7000,
                 16'h1000, 16'h4800, 16'h5555, 16'h2AAA, 16'h0800};
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i])
      issue(directed[i], 1'b0);
    for (int n = 0; n < 800; n++)
      issue(random_posit(), n >= 300 && n < 450);
    start <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
